@@ hw/rtl/uer_pkg.sv @@
`default_nettype none

package uer_pkg;

   // Default build parameters.
   localparam int READINGS_DEF   = 5;
   localparam int WIDTH_BITS_DEF = 18;

   // Microsecond ticks of echo per centimeter of distance.
   localparam int CM_DIVISOR = 58;

   // Field widths.
   localparam int TRIG_W   = 8;
   localparam int HOLD_W   = 20;
   localparam int DIST_W   = 17;
   localparam int CSR_AW   = 1;
   localparam int CSR_DW   = 20;
   localparam int REQ_DW   = 8;
   localparam int RSP_DW   = 24;

   // Largest distance that the result field can carry.
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // Register reset values.
   localparam logic [TRIG_W-1:0] TRIG_RESET = 8'd20;
   localparam logic [HOLD_W-1:0] HOLD_RESET = 20'd50000;

   // Configuration register indexes.
   localparam logic [CSR_AW-1:0] CSR_TRIG_WIDTH = 1'd0;
   localparam logic [CSR_AW-1:0] CSR_HOLDOFF    = 1'd1;

   // Measurement sequencer phases.
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_TRIG,
      PH_RISE,
      PH_MEAS,
      PH_HOLD
   } phase_type;

   // Strobes from the sequencer to the averaging unit.
   typedef struct packed {
      logic clear;
      logic add;
      logic capture;
   } avg_ctl_type;

   // Per-tick status bits, as they stand after the tick.
   typedef struct packed {
      logic trig;
      logic busy;
      logic done;
      logic saturated;
   } ctrl_res_type;

endpackage

`default_nettype wire

@@ hw/rtl/uer_avg.sv @@
`default_nettype none

module uer_avg #(
   parameter int READINGS   = uer_pkg::READINGS_DEF,
   parameter int WIDTH_BITS = uer_pkg::WIDTH_BITS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           step,
   input  wire uer_pkg::avg_ctl_type     ctl,
   output logic [uer_pkg::DIST_W-1:0]    distance_next
);
   import uer_pkg::*;

   // The running total of echo widths times 16 is kept as a quotient and a
   // remainder of the divisor. Each echo tick adds 16, which is below the
   // divisor, so one compare and subtract keeps the remainder in range.
   localparam int DIVISOR = CM_DIVISOR * READINGS;
   localparam int RW      = $clog2(DIVISOR);

   logic [WIDTH_BITS-1:0] quot_ff, quot_in;
   logic [RW-1:0]         rem_ff, rem_in;
   logic [DIST_W-1:0]     last_ff, last_in;
   logic [RW:0]           rem_sum;
   logic [DIST_W-1:0]     dist_clamp;

   always_comb begin
      rem_sum = {1'b0, rem_ff} + (RW+1)'(16);
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (ctl.clear) begin
         quot_in = '0;
         rem_in  = '0;
      end else if (ctl.add) begin
         if (rem_sum >= (RW+1)'(DIVISOR)) begin
            rem_in  = RW'(rem_sum - (RW+1)'(DIVISOR));
            quot_in = quot_ff + WIDTH_BITS'(1);
         end else begin
            rem_in  = RW'(rem_sum);
         end
      end
   end

   // Saturate the average to the result field.
   always_comb begin
      if (32'(quot_ff) > 32'(DIST_MAX)) begin
         dist_clamp = DIST_MAX;
      end else begin
         dist_clamp = DIST_W'(quot_ff);
      end
      last_in       = ctl.capture ? dist_clamp : last_ff;
      distance_next = last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_ff <= '0;
         rem_ff  <= '0;
         last_ff <= '0;
      end else if (step) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
         last_ff <= last_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/uer_ctrl.sv @@
`default_nettype none

module uer_ctrl #(
   parameter int READINGS   = uer_pkg::READINGS_DEF,
   parameter int WIDTH_BITS = uer_pkg::WIDTH_BITS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           step,
   input  wire                           start_req,
   input  wire                           echo,
   input  wire  [uer_pkg::TRIG_W-1:0]    trig_width,
   input  wire  [uer_pkg::HOLD_W-1:0]    holdoff,
   output uer_pkg::avg_ctl_type          avg_ctl,
   output uer_pkg::ctrl_res_type         res
);
   import uer_pkg::*;

   localparam int CW = $clog2(READINGS + 1);
   localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = '1;

   phase_type             phase_ff, phase_in;
   logic [HOLD_W-1:0]     timer_ff, timer_in;
   logic [WIDTH_BITS-1:0] width_ff, width_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  sat_ff, sat_in;
   logic [TRIG_W-1:0]     trig_len;

   // State register, advanced once per tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         timer_ff <= '0;
         width_ff <= '0;
         count_ff <= '0;
         sat_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         width_ff <= width_in;
         count_ff <= count_in;
         sat_ff   <= sat_in;
      end
   end

   // Next state and per-tick outputs.
   always_comb begin
      trig_len = (trig_width == '0) ? TRIG_W'(1) : trig_width;
      phase_in = phase_ff;
      timer_in = timer_ff;
      width_in = width_ff;
      count_in = count_ff;
      sat_in   = sat_ff;
      avg_ctl  = '0;
      res      = '0;

      unique case (phase_ff)
         PH_TRIG: begin
            if (timer_ff >= HOLD_W'(trig_len)) begin
               phase_in = PH_RISE;
            end else begin
               timer_in = timer_ff + HOLD_W'(1);
               res.trig = 1'b1;
            end
         end
         PH_RISE: begin
            // The first high sample already counts as one tick of width.
            if (echo) begin
               phase_in    = PH_MEAS;
               width_in    = WIDTH_BITS'(1);
               avg_ctl.add = 1'b1;
            end
         end
         PH_MEAS: begin
            if (echo) begin
               if (width_ff != WIDTH_MAX) begin
                  width_in    = width_ff + WIDTH_BITS'(1);
                  avg_ctl.add = 1'b1;
                  if (width_in == WIDTH_MAX) begin
                     sat_in = 1'b1;
                  end
               end
            end else begin
               count_in = count_ff + CW'(1);
               phase_in = PH_HOLD;
               timer_in = '0;
            end
         end
         PH_HOLD: begin
            if (timer_ff >= holdoff) begin
               if (count_ff >= CW'(READINGS)) begin
                  avg_ctl.capture = 1'b1;
                  res.done        = 1'b1;
                  phase_in        = PH_IDLE;
               end else begin
                  phase_in = PH_TRIG;
                  timer_in = HOLD_W'(1);
                  res.trig = 1'b1;
               end
            end else begin
               timer_in = timer_ff + HOLD_W'(1);
            end
         end
         default: begin
            // Idle, and any code that is not a phase.
            phase_in = PH_IDLE;
            if (start_req) begin
               phase_in      = PH_TRIG;
               timer_in      = HOLD_W'(1);
               width_in      = '0;
               count_in      = '0;
               sat_in        = 1'b0;
               avg_ctl.clear = 1'b1;
               res.trig      = 1'b1;
            end
         end
      endcase

      res.busy      = (phase_in != PH_IDLE);
      res.saturated = sat_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/ultrasonic_echo_ranger_avg_core.sv @@
`default_nettype none

// Ultrasonic echo ranger with averaging over several readings.
// Each request on the req_ channel is one microsecond tick: the start
// request and the sampled echo level. Each request produces exactly one
// result on the rsp_ channel with the trigger drive, busy, done, the
// average distance (centimeters, four fraction bits) and the saturation flag.
// A start in idle fires the trigger, times the echo high time, waits the
// hold-off, and repeats; after the last reading the average is reported.
// The average is built up as a running quotient while the echo is counted,
// so no divider is needed.
// A request reaches its result through the input register and then the
// result register. Throughput is one request per cycle while rsp_tready is high.
// The result register decouples the two sides; when rsp_tready is low the
// pending result holds, the input register still takes one more request,
// and req_tready then falls until the result is taken.
// Reset is synchronous: the sequencer goes idle, the stored distance clears,
// both configuration registers return to their reset values and no result
// is pending.
// The csr_ port writes a register and must only be used idle.
module ultrasonic_echo_ranger_avg_core #(
   parameter int READINGS   = uer_pkg::READINGS_DEF,
   parameter int WIDTH_BITS = uer_pkg::WIDTH_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   // Request channel.
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [uer_pkg::REQ_DW-1:0]   req_tdata,   // [0] start_req, [1] echo
   // Result channel.
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   // [0] trig, [1] busy_res, [2] done_res, [19:3] distance_q4, [20] saturated
   output logic [uer_pkg::RSP_DW-1:0]   rsp_tdata,
   // Configuration port.
   input  wire                          csr_we,
   input  wire  [uer_pkg::CSR_AW-1:0]   csr_addr,
   input  wire  [uer_pkg::CSR_DW-1:0]   csr_wdata
);
   import uer_pkg::*;

   logic                in_valid_ff, in_valid_in;
   logic                start_ff, echo_ff;
   logic                out_valid_ff, out_valid_in;
   logic                trig_ff, busy_ff, done_ff, sat_ff;
   logic [DIST_W-1:0]   dist_ff;
   logic [TRIG_W-1:0]   trig_width_ff;
   logic [HOLD_W-1:0]   holdoff_ff;
   logic                advance;
   avg_ctl_type         avg_ctl;
   ctrl_res_type        ctrl_res;
   logic [DIST_W-1:0]   dist_next;

   // Handshake: a held request moves on when the result register frees up.
   always_comb begin
      advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
      req_tready   = !in_valid_ff || advance;
      in_valid_in  = req_tvalid || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         start_ff <= req_tdata[0];
         echo_ff  <= req_tdata[1];
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         trig_width_ff <= TRIG_RESET;
         holdoff_ff    <= HOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_TRIG_WIDTH: trig_width_ff <= csr_wdata[TRIG_W-1:0];
            CSR_HOLDOFF:    holdoff_ff    <= csr_wdata[HOLD_W-1:0];
            default:        ;
         endcase
      end
   end

   uer_ctrl #(
      .READINGS   (READINGS),
      .WIDTH_BITS (WIDTH_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .start_req  (start_ff),
      .echo       (echo_ff),
      .trig_width (trig_width_ff),
      .holdoff    (holdoff_ff),
      .avg_ctl    (avg_ctl),
      .res        (ctrl_res)
   );

   uer_avg #(
      .READINGS   (READINGS),
      .WIDTH_BITS (WIDTH_BITS)
   ) u_avg (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .ctl           (avg_ctl),
      .distance_next (dist_next)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (advance) begin
         trig_ff <= ctrl_res.trig;
         busy_ff <= ctrl_res.busy;
         done_ff <= ctrl_res.done;
         sat_ff  <= ctrl_res.saturated;
         dist_ff <= dist_next;
      end
   end

   always_comb begin
      rsp_tvalid = out_valid_ff;
      rsp_tdata  = {3'b000, sat_ff, dist_ff, done_ff, busy_ff, trig_ff};
   end

endmodule

`default_nettype wire
